[src/lruc_pkg.sv]
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared sizes, codes, word types and helpers for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int RANK_W     = IDX_W;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;
    localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int IN_DATA_W  = KEY_W + VAL_W;
    localparam int OUT_DATA_W = VAL_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic             MODE_GET   = 1'b0;
    localparam logic             MODE_PUT   = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef logic [ENTRIES-1:0] mask_t;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } rsp_t;

    // keep only the lowest set bit
    function automatic mask_t lowest_set(input mask_t m);
        return m & (~m + mask_t'(1));
    endfunction

endpackage

[src/lruc_in_reg.sv]
// ----------------------------------------------------------------------------
// lruc_in_reg
// Input register: captures one request word and holds it until it advances.
// ----------------------------------------------------------------------------
module lruc_in_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tuser,
    input  logic [lruc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          advance,
    output logic                          req_valid,
    output lruc_pkg::req_t                req
);
    import lruc_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    req_t in_req_reg;

    assign s_tready  = !in_valid_reg || advance;
    assign req_valid = in_valid_reg;
    assign req       = in_req_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.mode  <= s_tuser;
            in_req_reg.key   <= s_tdata[KEY_W-1:0];
            in_req_reg.value <= s_tdata[KEY_W +: VAL_W];
        end
    end

endmodule

[src/lruc_store.sv]
// ----------------------------------------------------------------------------
// lruc_store
// Entry storage with parallel key match, recency ranks, eviction and insert.
// ----------------------------------------------------------------------------
module lruc_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lruc_pkg::CAP_W-1:0] cfg_data,
    input  logic                       advance,
    input  lruc_pkg::req_t             req,
    output lruc_pkg::rsp_t             rsp
);
    import lruc_pkg::*;

    logic [KEY_W-1:0]  keys_reg  [ENTRIES];
    logic [KEY_W-1:0]  keys_next [ENTRIES];
    logic [VAL_W-1:0]  vals_reg  [ENTRIES];
    logic [VAL_W-1:0]  vals_next [ENTRIES];
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    mask_t             valid_reg;
    mask_t             valid_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  cap_next;

    mask_t             match;
    mask_t             hit_oh;
    mask_t             victim_raw;
    mask_t             evict_oh;
    mask_t             valid_kept;
    mask_t             free_oh;
    logic              hit;
    logic              is_put;
    logic              full;
    logic              insert;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] last_rank;
    logic [VAL_W-1:0]  stored_val;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;

    assign cfg_ready = 1'b1;

    always_comb begin
        cap_next = cap_reg;
        if (cfg_valid) begin
            cap_next = cfg_data;
        end
    end

    // lookup
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (keys_reg[i] == req.key);
        end
        hit_oh     = lowest_set(match);
        hit        = |match;
        is_put     = (req.mode == MODE_PUT);
        old_rank   = '0;
        stored_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            old_rank   = old_rank   | (hit_oh[i] ? rank_reg[i] : '0);
            stored_val = stored_val | (hit_oh[i] ? vals_reg[i] : '0);
        end
    end

    // victim and free slot
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        eff_cap = cap_ext;
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end
        full      = CMP_W'(occ_reg) >= eff_cap;
        last_rank = RANK_W'(occ_reg - OCC_W'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            victim_raw[i] = valid_reg[i] && (rank_reg[i] == last_rank);
        end
        evict_oh   = (is_put && !hit && full) ? lowest_set(victim_raw) : '0;
        valid_kept = valid_reg & ~evict_oh;
        free_oh    = lowest_set(~valid_kept);
        insert     = is_put && !hit && (|(~valid_kept));
    end

    // state update
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            keys_next[i] = keys_reg[i];
            vals_next[i] = vals_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (advance) begin
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_oh[i]) begin
                        rank_next[i] = '0;
                        if (is_put) begin
                            vals_next[i] = req.value;
                        end
                    end else if (valid_reg[i] && (rank_reg[i] < old_rank)) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end else if (is_put) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (evict_oh[i]) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    if (insert) begin
                        if (free_oh[i]) begin
                            keys_next[i]  = req.key;
                            vals_next[i]  = req.value;
                            valid_next[i] = 1'b1;
                            rank_next[i]  = '0;
                        end else if (valid_kept[i]) begin
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                    end
                end
                occ_next = occ_reg - OCC_W'(|evict_oh) + OCC_W'(insert);
            end
        end
    end

    always_comb begin
        rsp.hit = hit;
        if (is_put) begin
            rsp.read_value = req.value;
        end else if (hit) begin
            rsp.read_value = stored_val;
        end else begin
            rsp.read_value = MISS_VALUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            keys_reg[i] <= keys_next[i];
            vals_reg[i] <= vals_next[i];
        end
    end

endmodule

[src/lruc_out_reg.sv]
// ----------------------------------------------------------------------------
// lruc_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module lruc_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  lruc_pkg::rsp_t                 rsp,
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_tuser,
    output logic [lruc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lruc_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_rsp_reg;

    assign free     = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.hit;
    assign m_tdata  = out_rsp_reg.read_value;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_rsp_reg <= rsp;
        end
    end

endmodule

[src/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request word is a get or a put of a 32-bit key. The word is captured in
// an input register, matched against every entry by combinational logic, and
// its result is written to an output register once that register is free or
// being taken; one request is taken every cycle while the result side keeps
// up, and a stalled result side holds the input after one more word. The
// single lookup-and-update stage over all entries sets this rate. A get miss
// returns all ones; a put returns the value written. The capacity register
// (reset 16, zero reads as one, clamped to the entry count) is to be written by
// the user through the cfg port only while no request is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lruc_pkg::CAP_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] mode
    input  logic [lruc_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] key, [63:32] value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,   // [0] hit
    output logic [lruc_pkg::OUT_DATA_W-1:0] m_tdata    // [31:0] read_value
);
    import lruc_pkg::*;

    logic req_valid;
    logic out_free;
    logic advance;
    req_t req;
    rsp_t rsp;

    assign advance = req_valid && out_free;

    lruc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    lruc_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .req       (req),
        .rsp       (rsp)
    );

    lruc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .rsp      (rsp),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

[src/lruc_checker.sv]
// ----------------------------------------------------------------------------
// lruc_checker
// Port-level checks for the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lruc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic                            m_tuser,
    input logic [lruc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lruc_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without accepted request");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lruc_checker u_lruc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

[sim/lru_key_value_cache_tb.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key/value cache: a short directed script with
// capacity changes, then random get/put traffic drawn from a small key pool so
// hits, updates and evictions are frequent. Every accepted request word runs
// through a behavioral copy of the cache whose response, or a scripted one, is
// queued and compared field by field with the response stream. Request and
// response sides idle at random in three styles; capacity changes by phase.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lruc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_POOL    = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_OPS   = 175;
    localparam int SETTLE      = 8;

    typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [CAP_W-1:0] cap;
        req_t             op;
        bit               fixed;
        rsp_t             want;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic                  s_tuser   = 1'b0;  // [0] mode
    logic [IN_DATA_W-1:0]  s_tdata   = '0;    // [31:0] key, [63:32] value
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  m_tuser;           // [0] hit
    logic [OUT_DATA_W-1:0] m_tdata;           // [31:0] read_value

    lru_key_value_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    logic [KEY_W-1:0] line_key [ENTRIES];
    logic [VAL_W-1:0] line_val [ENTRIES];
    bit               line_live [ENTRIES];
    int               line_age [ENTRIES];
    int               line_fill;
    logic [CAP_W-1:0] cap_now;

    rsp_t             pending [$];
    script_row_t      script [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    int err_count     = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic int cap_limit();
        if (cap_now == '0) return 1;
        if (cap_now > CAP_W'(ENTRIES)) return ENTRIES;
        return int'(cap_now);
    endfunction

    function automatic rsp_t lru_access(input req_t op);
        rsp_t res;
        int   found;
        int   victim;
        int   slot;
        int   old;
        found  = -1;
        victim = -1;
        slot   = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && line_live[i] && line_key[i] == op.key) found = i;
        if (found >= 0) begin
            if (op.mode == MODE_PUT) line_val[found] = op.value;
            old = line_age[found];
            for (int i = 0; i < ENTRIES; i++)
                if (line_live[i] && i != found && line_age[i] < old) line_age[i]++;
            line_age[found] = 0;
            res.hit        = 1'b1;
            res.read_value = line_val[found];
            return res;
        end
        res.hit = 1'b0;
        if (op.mode == MODE_GET) begin
            res.read_value = MISS_VALUE;
            return res;
        end
        if (line_fill >= cap_limit()) begin
            for (int i = 0; i < ENTRIES; i++)
                if (line_live[i] && (victim < 0 || line_age[i] > line_age[victim]))
                    victim = i;
            if (victim >= 0) begin
                line_live[victim] = 1'b0;
                line_age[victim]  = 0;
                line_fill--;
            end
        end
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !line_live[i]) slot = i;
        if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
                if (line_live[i]) line_age[i]++;
            line_key[slot]  = op.key;
            line_val[slot]  = op.value;
            line_live[slot] = 1'b1;
            line_age[slot]  = 0;
            line_fill++;
        end
        res.read_value = op.value;
        return res;
    endfunction

    function automatic void script_op(input logic mode, input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] value, input bit fixed,
                                      input logic hit, input logic [VAL_W-1:0] rv);
        script_row_t row;
        row.kind             = ROW_OP;
        row.cap              = '0;
        row.op.mode          = mode;
        row.op.key           = key;
        row.op.value         = value;
        row.fixed            = fixed;
        row.want.hit         = hit;
        row.want.read_value  = rv;
        script.push_back(row);
    endfunction

    function automatic void script_cap(input logic [CAP_W-1:0] cap);
        script_row_t row;
        row.kind  = ROW_CAP;
        row.cap   = cap;
        row.op    = '0;
        row.fixed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("lru_key_value_cache_tb: mismatch: %s", msg);
        err_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_now = cap;
    endtask

    task automatic send_word(input req_t op, input bit fixed, input rsp_t want);
        rsp_t got;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.mode;
        s_tdata  <= {op.value, op.key};
        do @(posedge aclk); while (!s_tready);
        got = lru_access(op);
        pending.push_back(fixed ? want : got);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        rsp_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending.size() == 0) begin
                report_mismatch("response word with nothing pending");
            end else begin
                want = pending.pop_front();
                if (m_tuser !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", m_tuser, want.hit));
                if (m_tdata !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              m_tdata, want.read_value));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_key_value_cache_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        req_t             op;
        rsp_t             none;
        logic [CAP_W-1:0] phase_cap [PHASES];
        for (int i = 0; i < ENTRIES; i++) begin
            line_key[i]  = '0;
            line_val[i]  = '0;
            line_live[i] = 1'b0;
            line_age[i]  = 0;
        end
        line_fill = 0;
        cap_now   = CAP_RESET;
        none      = '0;

        script_op(MODE_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, MISS_VALUE);
        script_op(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 32'h7fff_ffff);
        script_op(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000);
        script_op(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7fff_ffff);
        script_op(MODE_PUT, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
        script_op(MODE_GET, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, MISS_VALUE);
        script_op(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 32'hffff_ffff);
        script_op(MODE_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff);
        script_op(MODE_PUT, 32'h0000_0000, 32'h5a5a_5a5a, 1'b1, 1'b0, 32'h5a5a_5a5a);
        // shrink below occupancy: one eviction per put miss
        script_cap(CAP_W'(2));
        script_op(MODE_PUT, 32'h0000_0001, 32'h0000_0011, 1'b1, 1'b0, 32'h0000_0011);
        script_op(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_op(MODE_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_op(MODE_PUT, 32'h7fff_ffff, 32'h0000_0022, 1'b0, 1'b0, '0);
        script_cap(CAP_W'(0));
        script_op(MODE_PUT, 32'h0000_0002, 32'h0000_0033, 1'b0, 1'b0, '0);
        script_op(MODE_PUT, 32'h0000_0003, 32'h0000_0044, 1'b0, 1'b0, '0);
        script_op(MODE_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_op(MODE_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_cap(CAP_W'(31));
        script_op(MODE_PUT, 32'ha5a5_a5a5, 32'h0000_0001, 1'b0, 1'b0, '0);
        script_op(MODE_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_op(MODE_GET, 32'ha5a5_a5a5, 32'h0000_0000, 1'b0, 1'b0, '0);
        script_cap(CAP_RESET);

        phase_cap[0] = CAP_W'(16);
        phase_cap[1] = CAP_W'(1);
        phase_cap[2] = CAP_W'(31);
        phase_cap[3] = CAP_W'(0);
        phase_cap[4] = CAP_W'($urandom_range(2, 15));
        phase_cap[5] = CAP_W'($urandom_range(0, 31));

        send_idle_pct = 12;
        recv_idle_pct = 71;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[n]) begin
            if (script[n].kind == ROW_CAP) begin
                write_capacity(script[n].cap);
            end else begin
                send_word(script[n].op, script[n].fixed, script[n].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = (p < 2) ? 12 : (p < 4) ? 71 : 0;
            recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 12 : 0;
            write_capacity(phase_cap[p]);
            foreach (key_pool[k]) key_pool[k] = $urandom;
            for (int n = 0; n < PHASE_OPS; n++) begin
                op.mode  = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
                op.key   = ($urandom_range(0, 99) < 8) ? $urandom
                         : key_pool[$urandom_range(0, cap_limit() + 3)];
                op.value = $urandom;
                if ($urandom_range(0, 149) == 0) drain_results();
                send_word(op, 1'b0, none);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0) begin
            $display("lru_key_value_cache_tb: done, clean");
        end else begin
            $display("lru_key_value_cache_tb: done, errors");
        end
        $finish;
    end

endmodule
